### rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor engine: microcode
// step codes, control word, sequencer status, result kinds and char codes.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // sequencer steps (program addresses)
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DECODE = 3'd1,
        ST_SIM    = 3'd2,
        ST_REWIND = 3'd3,
        ST_WRITE  = 3'd4,
        ST_ONE    = 3'd5,
        ST_SCROLL = 3'd6
    } t_step;

    // datapath operation of one step
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_DECODE,
        DP_ADV,
        DP_REWIND
    } t_dp_op;

    // result issued by one step
    typedef enum logic [1:0] {
        EM_NONE,
        EM_CELL,
        EM_SCROLL,
        EM_ONE
    } t_emit;

    // jump conditions
    typedef enum logic [2:0] {
        CD_NEVER,
        CD_ALWAYS,
        CD_ACCEPT,
        CD_MULTI,
        CD_SCROLL,
        CD_CNT_LAST,
        CD_CNT_ZERO
    } t_cond;

    // result kinds on the output channel
    typedef enum logic [1:0] {
        K_CELL   = 2'd0,
        K_SCROLL = 2'd1,
        K_CLEAR  = 2'd2,
        K_CURSOR = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_FORE    = 2'd2,
        CFG_BACK    = 2'd3
    } t_cfg_reg;

    // one microcode word
    typedef struct packed {
        logic   in_ready;
        t_dp_op dp;
        t_emit  emit;
        t_cond  cond_a;
        t_step  tgt_a;
        t_cond  cond_b;
        t_step  tgt_b;
        t_step  tgt_else;
    } t_cw;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic step_en;
        logic in_valid;
        logic multi;
        logic scroll;
        logic cnt_last;
        logic cnt_zero;
    } t_status;

    localparam logic [7:0]  CH_BS       = 8'h08;
    localparam logic [7:0]  CH_TAB      = 8'h09;
    localparam logic [7:0]  CH_LF       = 8'h0A;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_BLANK    = 8'h20;
    localparam logic [7:0]  CH_PRINT_LO = 8'h20;
    localparam logic [7:0]  CH_PRINT_HI = 8'h7F;
    localparam logic [3:0]  TAB_STOP    = 4'd8;

    localparam logic [7:0]  COLUMNS_RST = 8'd80;
    localparam logic [6:0]  ROWS_RST    = 7'd25;
    localparam logic [23:0] FORE_RST    = 24'hCCCCCC;
    localparam logic [23:0] BACK_RST    = 24'h000000;

endpackage

### rtl/core/tcc_seq.sv
// ----------------------------------------------------------------------------
// tcc_seq
// Microcode sequencer: step counter, control store and two-way conditional
// jumps. The step holds while the datapath stalls on a full output register.
// ----------------------------------------------------------------------------
module tcc_seq
    import tcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cw     o_cw
);

    t_step r_step;
    t_step n_step;

    // control store
    function automatic t_cw ucode(input t_step s);
        t_cw w;
        case (s)
            ST_IDLE:   w = '{1'b1, DP_LOAD, EM_NONE, CD_ACCEPT, ST_DECODE,
                             CD_NEVER, ST_IDLE, ST_IDLE};
            ST_DECODE: w = '{1'b0, DP_DECODE, EM_NONE, CD_MULTI, ST_SIM,
                             CD_NEVER, ST_IDLE, ST_ONE};
            ST_SIM:    w = '{1'b0, DP_ADV, EM_NONE, CD_CNT_LAST, ST_REWIND,
                             CD_NEVER, ST_IDLE, ST_SIM};
            ST_REWIND: w = '{1'b0, DP_REWIND, EM_NONE, CD_ALWAYS, ST_WRITE,
                             CD_NEVER, ST_IDLE, ST_WRITE};
            ST_WRITE:  w = '{1'b0, DP_ADV, EM_CELL, CD_SCROLL, ST_SCROLL,
                             CD_CNT_LAST, ST_IDLE, ST_WRITE};
            ST_ONE:    w = '{1'b0, DP_NOP, EM_ONE, CD_ALWAYS, ST_IDLE,
                             CD_NEVER, ST_IDLE, ST_IDLE};
            ST_SCROLL: w = '{1'b0, DP_NOP, EM_SCROLL, CD_CNT_ZERO, ST_IDLE,
                             CD_NEVER, ST_IDLE, ST_WRITE};
            default:   w = '{1'b1, DP_LOAD, EM_NONE, CD_ACCEPT, ST_DECODE,
                             CD_NEVER, ST_IDLE, ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic cond_true(input t_cond c, input t_status st);
        logic v;
        case (c)
            CD_NEVER:    v = 1'b0;
            CD_ALWAYS:   v = 1'b1;
            CD_ACCEPT:   v = st.in_valid;
            CD_MULTI:    v = st.multi;
            CD_SCROLL:   v = st.scroll;
            CD_CNT_LAST: v = st.cnt_last;
            CD_CNT_ZERO: v = st.cnt_zero;
            default:     v = 1'b0;
        endcase
        return v;
    endfunction

    // output decode: current control word
    always_comb begin
        o_cw = ucode(r_step);
    end

    // next step
    always_comb begin
        if (!i_status.step_en) begin
            n_step = r_step;
        end else if (cond_true(o_cw.cond_a, i_status)) begin
            n_step = o_cw.tgt_a;
        end else if (cond_true(o_cw.cond_b, i_status)) begin
            n_step = o_cw.tgt_b;
        end else begin
            n_step = o_cw.tgt_else;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### rtl/core/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Keeps the cursor of a character grid and turns character bytes and clear
// commands into cell-write, scroll, clear and cursor-only transfers.
// Sequence: an accepted item is decoded, then a single-result command issues
//   its one result; a printable byte or tab walks the cursor once to find the
//   final cursor, rewinds and walks it again, issuing cell writes and scrolls.
// Throughput: one item at a time; next input accepted once the last result
//   is registered. Reset: synchronous, clears cursor and step, loads config
//   defaults.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
    import tcc_pkg::*;
#(
    parameter int COL_CAP = 128,
    parameter int ROW_CAP = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_char_code,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_cell_row,
    output logic [6:0]  o_cell_col,
    output logic [7:0]  o_glyph,
    output logic [23:0] o_fg_out,
    output logic [23:0] o_bg_out,
    output logic [5:0]  o_cur_row,
    output logic [6:0]  o_cur_col,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam logic [7:0] COL_LIM = 8'((COL_CAP < 128) ? COL_CAP : 128);
    localparam logic [6:0] ROW_LIM = 7'((ROW_CAP < 64) ? ROW_CAP : 64);

    // configuration registers
    logic [7:0]  r_columns;
    logic [6:0]  r_rows;
    logic [23:0] r_fore;
    logic [23:0] r_back;

    // cursor, walk and command registers
    logic [6:0]  r_cur_col,  n_cur_col;
    logic [5:0]  r_cur_line, n_cur_line;
    logic [6:0]  r_base_col, n_base_col;
    logic [5:0]  r_base_line, n_base_line;
    logic [6:0]  r_fin_col,  n_fin_col;
    logic [5:0]  r_fin_line, n_fin_line;
    logic [3:0]  r_cnt,      n_cnt;
    logic [3:0]  r_cnt_init, n_cnt_init;
    logic [7:0]  r_glyph,    n_glyph;
    t_kind       r_kind,     n_kind;
    logic        r_op,       n_op;
    logic [7:0]  r_ch,       n_ch;

    // output register
    logic        r_o_valid,  n_o_valid;
    t_kind       r_o_kind,   n_o_kind;
    logic [5:0]  r_o_row,    n_o_row;
    logic [6:0]  r_o_col,    n_o_col;
    logic [7:0]  r_o_glyph,  n_o_glyph;
    logic [23:0] r_o_fg,     n_o_fg;
    logic [23:0] r_o_bg,     n_o_bg;
    logic [5:0]  r_o_crow,   n_o_crow;
    logic [6:0]  r_o_ccol,   n_o_ccol;
    logic        r_o_last,   n_o_last;

    t_cw         w_cw;
    t_status     w_status;
    logic        w_step_en;
    logic        w_accept;

    logic [7:0]  w_ncols;
    logic [6:0]  w_nrows;
    logic [6:0]  w_last_col;
    logic [5:0]  w_last_line;
    logic [6:0]  w_sat_col;
    logic [5:0]  w_sat_line;
    logic [6:0]  w_sat_line_inc;

    logic [7:0]  w_col_inc;
    logic [6:0]  w_line_inc;
    logic        w_wrap;
    logic        w_adv_scroll;
    logic [6:0]  w_adv_col;
    logic [5:0]  w_adv_line;

    logic        w_multi;
    logic [6:0]  w_d_col;
    logic [5:0]  w_d_line;
    t_kind       w_d_kind;
    logic [7:0]  w_d_glyph;
    logic [3:0]  w_d_cnt;

    // sequencer
    tcc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cw     (w_cw)
    );

    // an issuing step waits for a free output register
    assign w_step_en = (w_cw.emit == EM_NONE) || !r_o_valid || i_out_ready;
    assign o_in_ready = w_cw.in_ready;
    assign w_accept   = i_in_valid && w_cw.in_ready;

    assign w_status = '{
        step_en:  w_step_en,
        in_valid: i_in_valid,
        multi:    w_multi,
        scroll:   w_adv_scroll,
        cnt_last: (r_cnt == 4'd1),
        cnt_zero: (r_cnt == 4'd0)
    };

    // grid size in use: zero reads as one, saturated to the limit
    always_comb begin
        if (r_columns == 8'd0) begin
            w_ncols = 8'd1;
        end else if (r_columns > COL_LIM) begin
            w_ncols = COL_LIM;
        end else begin
            w_ncols = r_columns;
        end
        if (r_rows == 7'd0) begin
            w_nrows = 7'd1;
        end else if (r_rows > ROW_LIM) begin
            w_nrows = ROW_LIM;
        end else begin
            w_nrows = r_rows;
        end
    end

    assign w_last_col  = 7'(w_ncols - 8'd1);
    assign w_last_line = 6'(w_nrows - 7'd1);

    // cursor clamped into the grid (after a shrink)
    assign w_sat_col  = ({1'b0, r_cur_col} >= w_ncols) ? w_last_col : r_cur_col;
    assign w_sat_line = ({1'b0, r_cur_line} >= w_nrows) ? w_last_line : r_cur_line;
    assign w_sat_line_inc = {1'b0, w_sat_line} + 7'd1;

    // one advance of the walking cursor
    assign w_col_inc    = {1'b0, r_cur_col} + 8'd1;
    assign w_line_inc   = {1'b0, r_cur_line} + 7'd1;
    assign w_wrap       = (w_col_inc >= w_ncols);
    assign w_adv_scroll = w_wrap && (w_line_inc >= w_nrows);
    assign w_adv_col    = w_wrap ? 7'd0 : w_col_inc[6:0];
    assign w_adv_line   = !w_wrap ? r_cur_line :
                          (w_adv_scroll ? w_last_line : w_line_inc[5:0]);

    // command decode
    assign w_multi = !r_op && ((r_ch == CH_TAB) ||
                               ((r_ch >= CH_PRINT_LO) && (r_ch <= CH_PRINT_HI)));
    assign w_d_cnt = (r_ch == CH_TAB) ? (TAB_STOP - {1'b0, w_sat_col[2:0]}) : 4'd1;

    // final cursor and result of the single-result commands
    always_comb begin
        w_d_col   = w_sat_col;
        w_d_line  = w_sat_line;
        w_d_kind  = K_CURSOR;
        w_d_glyph = r_ch;
        if (r_op) begin
            w_d_col   = 7'd0;
            w_d_line  = 6'd0;
            w_d_kind  = K_CLEAR;
            w_d_glyph = CH_BLANK;
        end else begin
            case (r_ch)
                CH_LF: begin
                    w_d_col = 7'd0;
                    if (w_sat_line_inc >= w_nrows) begin
                        w_d_line  = w_last_line;
                        w_d_kind  = K_SCROLL;
                        w_d_glyph = CH_BLANK;
                    end else begin
                        w_d_line = w_sat_line_inc[5:0];
                    end
                end
                CH_CR: begin
                    w_d_col = 7'd0;
                end
                CH_BS: begin
                    // step back, wrapping to the end of the previous line
                    if (w_sat_col != 7'd0) begin
                        w_d_col = w_sat_col - 7'd1;
                    end else if (w_sat_line != 6'd0) begin
                        w_d_col  = w_last_col;
                        w_d_line = w_sat_line - 6'd1;
                    end
                    w_d_kind  = K_CELL;
                    w_d_glyph = CH_BLANK;
                end
                CH_TAB: begin
                    w_d_glyph = CH_BLANK;
                end
                default: begin
                    w_d_glyph = r_ch;
                end
            endcase
        end
    end

    // datapath next values
    always_comb begin
        n_cur_col   = r_cur_col;
        n_cur_line  = r_cur_line;
        n_base_col  = r_base_col;
        n_base_line = r_base_line;
        n_fin_col   = r_fin_col;
        n_fin_line  = r_fin_line;
        n_cnt       = r_cnt;
        n_cnt_init  = r_cnt_init;
        n_glyph     = r_glyph;
        n_kind      = r_kind;
        n_op        = r_op;
        n_ch        = r_ch;
        if (w_step_en) begin
            case (w_cw.dp)
                DP_LOAD: begin
                    if (w_accept) begin
                        n_op = i_opcode;
                        n_ch = i_char_code;
                    end
                end
                DP_DECODE: begin
                    n_base_col  = w_sat_col;
                    n_base_line = w_sat_line;
                    n_fin_col   = w_d_col;
                    n_fin_line  = w_d_line;
                    n_cnt       = w_d_cnt;
                    n_cnt_init  = w_d_cnt;
                    n_glyph     = w_d_glyph;
                    n_kind      = w_d_kind;
                    n_cur_col   = w_multi ? w_sat_col : w_d_col;
                    n_cur_line  = w_multi ? w_sat_line : w_d_line;
                end
                DP_ADV: begin
                    n_cur_col  = w_adv_col;
                    n_cur_line = w_adv_line;
                    n_cnt      = r_cnt - 4'd1;
                end
                DP_REWIND: begin
                    // first walk gave the final cursor; walk again and issue
                    n_fin_col  = r_cur_col;
                    n_fin_line = r_cur_line;
                    n_cur_col  = r_base_col;
                    n_cur_line = r_base_line;
                    n_cnt      = r_cnt_init;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_comb begin
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_kind  = r_o_kind;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_glyph = r_o_glyph;
        n_o_fg    = r_o_fg;
        n_o_bg    = r_o_bg;
        n_o_crow  = r_o_crow;
        n_o_ccol  = r_o_ccol;
        n_o_last  = r_o_last;
        if (w_step_en && (w_cw.emit != EM_NONE)) begin
            n_o_valid = 1'b1;
            n_o_row   = 6'd0;
            n_o_col   = 7'd0;
            n_o_glyph = CH_BLANK;
            n_o_fg    = r_fore;
            n_o_bg    = r_back;
            n_o_crow  = r_fin_line;
            n_o_ccol  = r_fin_col;
            n_o_last  = 1'b1;
            case (w_cw.emit)
                EM_CELL: begin
                    n_o_kind  = K_CELL;
                    n_o_row   = r_cur_line;
                    n_o_col   = r_cur_col;
                    n_o_glyph = r_glyph;
                    n_o_last  = (r_cnt == 4'd1) && !w_adv_scroll;
                end
                EM_SCROLL: begin
                    n_o_kind = K_SCROLL;
                    n_o_last = (r_cnt == 4'd0);
                end
                default: begin
                    n_o_kind = r_kind;
                    case (r_kind)
                        K_CELL: begin
                            n_o_row   = r_fin_line;
                            n_o_col   = r_fin_col;
                            n_o_glyph = r_glyph;
                        end
                        K_CURSOR: begin
                            n_o_glyph = 8'd0;
                            n_o_fg    = 24'd0;
                            n_o_bg    = 24'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end
    end

    // control and cursor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns  <= COLUMNS_RST;
            r_rows     <= ROWS_RST;
            r_fore     <= FORE_RST;
            r_back     <= BACK_RST;
            r_cur_col  <= 7'd0;
            r_cur_line <= 6'd0;
            r_cnt      <= 4'd0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COLUMNS: r_columns <= i_cfg_data[7:0];
                    CFG_ROWS:    r_rows    <= i_cfg_data[6:0];
                    CFG_FORE:    r_fore    <= i_cfg_data;
                    CFG_BACK:    r_back    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_cur_col  <= n_cur_col;
            r_cur_line <= n_cur_line;
            r_cnt      <= n_cnt;
            r_o_valid  <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base_col  <= n_base_col;
        r_base_line <= n_base_line;
        r_fin_col   <= n_fin_col;
        r_fin_line  <= n_fin_line;
        r_cnt_init  <= n_cnt_init;
        r_glyph     <= n_glyph;
        r_kind      <= n_kind;
        r_op        <= n_op;
        r_ch        <= n_ch;
        r_o_kind    <= n_o_kind;
        r_o_row     <= n_o_row;
        r_o_col     <= n_o_col;
        r_o_glyph   <= n_o_glyph;
        r_o_fg      <= n_o_fg;
        r_o_bg      <= n_o_bg;
        r_o_crow    <= n_o_crow;
        r_o_ccol    <= n_o_ccol;
        r_o_last    <= n_o_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_cell_row  = r_o_row;
    assign o_cell_col  = r_o_col;
    assign o_glyph     = r_o_glyph;
    assign o_fg_out    = r_o_fg;
    assign o_bg_out    = r_o_bg;
    assign o_cur_row   = r_o_crow;
    assign o_cur_col   = r_o_ccol;
    assign o_last      = r_o_last;

    // tab count never exceeds one tab stop of cells
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= TAB_STOP)
        else $error("cell counter out of range");

    // an accepted item is decoded in the next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_cw.dp == DP_DECODE))
        else $error("accepted item not decoded");

    // a cursor-only result is always the only one of its item
    a_cursor_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_kind == K_CURSOR)) |-> r_o_last)
        else $error("cursor-only result not marked last");

endmodule
